>>> hdl/cga_pkg.sv
package cga_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned LenW   = 16;
    localparam int unsigned CountW = 3;
    localparam int unsigned AddrW  = 5;
    localparam int unsigned NumLens = 4;

    // Register indexes, one word apart on the configuration port.
    typedef enum logic [2:0] {
        REG_PART_COUNT  = 3'd0,
        REG_LEN_PART0   = 3'd1,
        REG_LEN_PART1   = 3'd2,
        REG_LEN_PART2   = 3'd3,
        REG_LEN_PART3   = 3'd4,
        REG_INNER_SIZE  = 3'd5,
        REG_AXIS_LENGTH = 3'd6
    } t_reg_idx;

    // One slot of a restoring divider chain.
    typedef struct packed {
        logic             vld;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] num;
        logic [DataW-1:0] quo;
    } t_div;

    // Static configuration handed to the mapping stages.
    typedef struct packed {
        logic [NumLens-1:0][LenW-1:0] len;
        logic [LenW-1:0]              inner;
        logic [CountW-1:0]            count;
    } t_map_cfg;

endpackage

>>> hdl/cga_div_cell.sv
module cga_div_cell #(
    parameter int unsigned SW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [cga_pkg::DataW-1:0]   i_divisor,
    input  cga_pkg::t_div               i_d,
    input  logic [SW-1:0]               i_side,
    output cga_pkg::t_div               o_d,
    output logic [SW-1:0]               o_side
);
    import cga_pkg::*;

    logic [DataW:0] trial;
    logic [DataW:0] diff;
    logic           ge;
    t_div           n_d;
    t_div           r_d;
    logic [SW-1:0]  r_side;

    // One quotient bit: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial   = {i_d.rem, i_d.num[DataW-1]};
        diff    = trial - {1'b0, i_divisor};
        ge      = (trial >= {1'b0, i_divisor});
        n_d.vld = i_d.vld;
        n_d.rem = ge ? diff[DataW-1:0] : trial[DataW-1:0];
        n_d.num = {i_d.num[DataW-2:0], 1'b0};
        n_d.quo = {i_d.quo[DataW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d.vld <= n_d.vld;
        end
        if (i_en) begin
            r_d.rem <= n_d.rem;
            r_d.num <= n_d.num;
            r_d.quo <= n_d.quo;
            r_side  <= i_side;
        end
    end

    assign o_d    = r_d;
    assign o_side = r_side;

endmodule

>>> hdl/cga_div_chain.sv
module cga_div_chain #(
    parameter int unsigned NCELL = 32,
    parameter int unsigned SW    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [cga_pkg::DataW-1:0]   i_divisor,
    input  cga_pkg::t_div               i_d,
    input  logic [SW-1:0]               i_side,
    output cga_pkg::t_div               o_d,
    output logic [SW-1:0]               o_side
);
    import cga_pkg::*;

    t_div          stage_d [NCELL+1];
    logic [SW-1:0] stage_s [NCELL+1];

    assign stage_d[0] = i_d;
    assign stage_s[0] = i_side;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cga_div_cell #(.SW(SW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (i_en),
            .i_divisor (i_divisor),
            .i_d       (stage_d[g]),
            .i_side    (stage_s[g]),
            .o_d       (stage_d[g+1]),
            .o_side    (stage_s[g+1])
        );
    end

    assign o_d    = stage_d[NCELL];
    assign o_side = stage_s[NCELL];

endmodule

>>> hdl/cga_map.sv
module cga_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  cga_pkg::t_map_cfg           i_cfg,
    input  logic                        i_vld,
    input  logic                        i_zero,
    input  logic [cga_pkg::DataW-1:0]   i_outer,
    input  logic [cga_pkg::LenW-1:0]    i_ax,
    input  logic [cga_pkg::LenW-1:0]    i_inr,
    output logic                        o_vld,
    output logic [1:0]                  o_part,
    output logic [cga_pkg::DataW-1:0]   o_src,
    output logic                        o_owned
);
    import cga_pkg::*;

    localparam int unsigned BW = LenW + 2;

    logic [NumLens-1:0][BW-1:0] base;
    logic [1:0]                 sel_part;
    logic                       sel_hit;
    logic [LenW-1:0]            sel_len;
    logic [LenW-1:0]            sel_off;
    logic [BW-1:0]              ax_w;
    logic [BW-1:0]              lim;

    // Stage A: part search.
    logic            r_a_vld;
    logic [1:0]      r_a_part;
    logic            r_a_hit;
    logic [LenW-1:0] r_a_len;
    logic [LenW-1:0] r_a_off;
    logic [DataW-1:0] r_a_outer;
    logic [LenW-1:0] r_a_inr;
    // Stage B: outer times part length.
    logic            r_b_vld;
    logic [1:0]      r_b_part;
    logic            r_b_hit;
    logic [DataW-1:0] r_b_row;
    logic [LenW-1:0] r_b_inr;
    // Stage C: scale by inner size.
    logic            r_c_vld;
    logic [1:0]      r_c_part;
    logic            r_c_hit;
    logic [DataW-1:0] r_c_src;

    logic [DataW+LenW-1:0] prod_b;
    logic [DataW+LenW-1:0] prod_c;
    logic [DataW-1:0]      n_b_row;
    logic [DataW-1:0]      n_c_src;

    always_comb begin
        ax_w     = {2'b0, i_ax};
        base[0]  = '0;
        for (int p = 1; p < NumLens; p++) begin
            base[p] = base[p-1] + {2'b0, i_cfg.len[p-1]};
        end
        sel_part = '0;
        sel_hit  = 1'b0;
        sel_len  = '0;
        sel_off  = '0;
        lim      = '0;
        for (int p = NumLens - 1; p >= 0; p--) begin
            lim = base[p] + {2'b0, i_cfg.len[p]};
            if ((CountW'(p) < i_cfg.count) && (ax_w >= base[p]) && (ax_w < lim)) begin
                sel_part = 2'(p);
                sel_hit  = 1'b1;
                sel_len  = i_cfg.len[p];
                sel_off  = i_ax - base[p][LenW-1:0];
            end
        end
    end

    assign prod_b  = r_a_outer * r_a_len;
    assign n_b_row = prod_b[DataW-1:0] + {{(DataW-LenW){1'b0}}, r_a_off};
    assign prod_c  = r_b_row * i_cfg.inner;
    assign n_c_src = prod_c[DataW-1:0] + {{(DataW-LenW){1'b0}}, r_b_inr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
        if (i_en) begin
            r_a_part  <= sel_part;
            r_a_hit   <= sel_hit && !i_zero;
            r_a_len   <= sel_len;
            r_a_off   <= sel_off;
            r_a_outer <= i_outer;
            r_a_inr   <= i_inr;
            r_b_part  <= r_a_part;
            r_b_hit   <= r_a_hit;
            r_b_row   <= n_b_row;
            r_b_inr   <= r_a_inr;
            r_c_part  <= r_b_hit ? r_b_part : 2'd0;
            r_c_hit   <= r_b_hit;
            r_c_src   <= r_b_hit ? n_c_src : '0;
        end
    end

    assign o_vld   = r_c_vld;
    assign o_part  = r_c_part;
    assign o_src   = r_c_src;
    assign o_owned = r_c_hit;

endmodule

>>> hdl/concat_gather_address_top.sv
// Concatenation gather address generator.
// An accepted item passes through 32 divider cells for the outer split, 16 cells for
// the axis split and three mapping stages.
// Throughput: one item per cycle while results are taken; the chain of divider cells sets this figure.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module concat_gather_address_top #(
    parameter int unsigned MAX_PARTS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cga_pkg::DataW-1:0]     i_output_index,
    // Result item channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_source_part,
    output logic [cga_pkg::DataW-1:0]     o_source_index,
    output logic                          o_owned,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cga_pkg::AddrW-1:0]     paddr,
    input  logic [cga_pkg::DataW-1:0]     pwdata,
    output logic [cga_pkg::DataW-1:0]     prdata,
    output logic                          pready
);
    import cga_pkg::*;

    localparam logic [CountW-1:0] MaxCount = CountW'(MAX_PARTS);

    // Configuration registers.
    logic [CountW-1:0]            r_part_count;
    logic [NumLens-1:0][LenW-1:0] r_len;
    logic [LenW-1:0]              r_inner;
    logic [LenW-1:0]              r_axis;
    logic [LenW-1:0]              n_inner;
    logic [LenW-1:0]              n_axis;
    logic [DataW-1:0]             r_span;
    logic                         r_zero;
    logic                         wr_en;
    t_reg_idx                     wr_idx;

    // The whole pipeline advances together; it holds only while a finished
    // item sits at the output and is not being taken.
    logic     en;
    t_div     d1_in;
    t_div     d1_out;
    logic     z1_out;
    t_div     d2_in;
    t_div     d2_out;
    logic [DataW:0] side2_out;
    t_map_cfg map_cfg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = t_reg_idx'(paddr[AddrW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_count <= 3'd2;
            r_len        <= '0;
            r_inner      <= 16'd1;
            r_axis       <= 16'd1;
        end else if (wr_en) begin
            case (wr_idx)
                REG_PART_COUNT:  r_part_count <= pwdata[CountW-1:0];
                REG_LEN_PART0:   r_len[0]     <= pwdata[LenW-1:0];
                REG_LEN_PART1:   r_len[1]     <= pwdata[LenW-1:0];
                REG_LEN_PART2:   r_len[2]     <= pwdata[LenW-1:0];
                REG_LEN_PART3:   r_len[3]     <= pwdata[LenW-1:0];
                REG_INNER_SIZE:  r_inner      <= pwdata[LenW-1:0];
                REG_AXIS_LENGTH: r_axis       <= pwdata[LenW-1:0];
                default: ;
            endcase
        end
    end

    // The span and the zero-divisor flag are formed from the values the
    // registers take at this edge, so they are current at the same edge as
    // the registers and an item may follow a write right away.
    always_comb begin
        n_inner = r_inner;
        n_axis  = r_axis;
        if (wr_en && wr_idx == REG_INNER_SIZE) begin
            n_inner = pwdata[LenW-1:0];
        end
        if (wr_en && wr_idx == REG_AXIS_LENGTH) begin
            n_axis = pwdata[LenW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= 32'd1;
            r_zero <= 1'b0;
        end else begin
            r_span <= n_axis * n_inner;
            r_zero <= (n_axis == '0) || (n_inner == '0);
        end
    end

    always_comb begin
        prdata = '0;
        case (wr_idx)
            REG_PART_COUNT:  prdata = {{(DataW-CountW){1'b0}}, r_part_count};
            REG_LEN_PART0:   prdata = {{(DataW-LenW){1'b0}}, r_len[0]};
            REG_LEN_PART1:   prdata = {{(DataW-LenW){1'b0}}, r_len[1]};
            REG_LEN_PART2:   prdata = {{(DataW-LenW){1'b0}}, r_len[2]};
            REG_LEN_PART3:   prdata = {{(DataW-LenW){1'b0}}, r_len[3]};
            REG_INNER_SIZE:  prdata = {{(DataW-LenW){1'b0}}, r_inner};
            REG_AXIS_LENGTH: prdata = {{(DataW-LenW){1'b0}}, r_axis};
            default:         prdata = '0;
        endcase
    end

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // First split: output index by span gives the outer coordinate and
    // the remainder within one outer slice.
    assign d1_in.vld = i_in_valid;
    assign d1_in.rem = '0;
    assign d1_in.num = i_output_index;
    assign d1_in.quo = '0;

    cga_div_chain #(.NCELL(DataW), .SW(1)) u_div_outer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_divisor (r_span),
        .i_d       (d1_in),
        .i_side    (r_zero),
        .o_d       (d1_out),
        .o_side    (z1_out)
    );

    // Second split: the remainder by inner size. The quotient is below the
    // axis length, so the upper half of the remainder seeds the partial
    // remainder and only sixteen quotient bits are formed.
    assign d2_in.vld = d1_out.vld;
    assign d2_in.rem = {{(DataW-LenW){1'b0}}, d1_out.rem[DataW-1:LenW]};
    assign d2_in.num = {d1_out.rem[LenW-1:0], {(DataW-LenW){1'b0}}};
    assign d2_in.quo = '0;

    cga_div_chain #(.NCELL(LenW), .SW(DataW+1)) u_div_axis (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_divisor ({{(DataW-LenW){1'b0}}, r_inner}),
        .i_d       (d2_in),
        .i_side    ({z1_out, d1_out.quo}),
        .o_d       (d2_out),
        .o_side    (side2_out)
    );

    assign map_cfg.len   = r_len;
    assign map_cfg.inner = r_inner;
    assign map_cfg.count = (r_part_count > MaxCount) ? MaxCount : r_part_count;

    cga_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (map_cfg),
        .i_vld   (d2_out.vld),
        .i_zero  (side2_out[DataW]),
        .i_outer (side2_out[DataW-1:0]),
        .i_ax    (d2_out.quo[LenW-1:0]),
        .i_inr   (d2_out.rem[LenW-1:0]),
        .o_vld   (o_out_valid),
        .o_part  (o_source_part),
        .o_src   (o_source_index),
        .o_owned (o_owned)
    );

    // An unowned element carries zero fields.
    a_unowned_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_owned |-> o_source_part == 2'd0 && o_source_index == '0)
        else $error("unowned item carries nonzero fields");

    // An owning part always lies within the active part count.
    a_part_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_owned |-> {1'b0, o_source_part} < map_cfg.count)
        else $error("owning part beyond part count");

    // Zero divisors never yield an owned item.
    a_zero_unowned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_zero && $stable(r_zero) && $past(r_zero, 51) |-> !o_owned)
        else $error("owned item with zero divisor");

    // A held result holds the input side too.
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while the pipeline is held");

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import cga_pkg::*;

    // Pipeline depth of the block, the sum of its divider cells and mapping stages.
    localparam int unsigned PipeDepth = 51;
    localparam int unsigned CycleLimit = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [DataW-1:0]     i_output_index = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_source_part;
    logic [DataW-1:0]     o_source_index;
    logic                 o_owned;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrW-1:0]     paddr = '0;
    logic [DataW-1:0]     pwdata = '0;
    logic [DataW-1:0]     prdata;
    logic                 pready;

    concat_gather_address_top dut (.*);

    // A mapped address: owning part, index within it, and the owned flag.
    typedef struct packed {
        logic [1:0]       part;
        logic [DataW-1:0] index;
        logic             owned;
    } t_gather;

    // Shadow copy of the configuration registers.
    logic [CountW-1:0] cfg_count;
    logic [LenW-1:0]   cfg_len [NumLens];
    logic [LenW-1:0]   cfg_inner;
    logic [LenW-1:0]   cfg_axis;

    logic [DataW-1:0]  index_queue [$];
    t_gather           gather_queue [$];
    int unsigned       mismatches = 0;
    int unsigned       cycles = 0;
    int unsigned       hold_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Computes where one output element of the concatenation comes from.
    function automatic t_gather map_output_index(input logic [DataW-1:0] idx);
        t_gather    res;
        logic [31:0] span, outer, rem, ax, inr, base, len;
        int unsigned n;
        res = '0;
        if (cfg_inner != 0 && cfg_axis != 0) begin
            span  = 32'(cfg_axis) * 32'(cfg_inner);
            outer = idx / span;
            rem   = idx % span;
            ax    = rem / 32'(cfg_inner);
            inr   = rem % 32'(cfg_inner);
            n     = (cfg_count > NumLens) ? NumLens : cfg_count;
            base  = 0;
            for (int p = 0; p < n; p++) begin
                len = 32'(cfg_len[p]);
                if (!res.owned && ax >= base && ax < base + len) begin
                    res.index = (outer * len + (ax - base)) * 32'(cfg_inner) + inr;
                    res.part  = 2'(p);
                    res.owned = 1'b1;
                end
                base += len;
            end
        end
        return res;
    endfunction

    // Random gap length: usually none or short, now and then long.
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offers the pending items, with random gaps between them.
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                void'(index_queue.pop_front());
                gather_queue.push_back(map_output_index(i_output_index));
            end
            if (i_in_valid && !o_in_ready) begin
                // Hold the item until it is taken.
            end else if (send_gap != 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (index_queue.size() != 0) begin
                i_in_valid     <= 1'b1;
                i_output_index <= index_queue[0];
                send_gap       <= gap_length();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result against the oldest expectation.
    int unsigned recv_gap = 0;
    always @(posedge i_clk) begin
        t_gather exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (gather_queue.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected item: part %0d index %h owned %b",
                                 o_source_part, o_source_index, o_owned);
                end else begin
                    exp_r = gather_queue.pop_front();
                    if (exp_r.part !== o_source_part || exp_r.index !== o_source_index
                        || exp_r.owned !== o_owned) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected part %0d index %h owned %b, got %0d %h %b",
                                     exp_r.part, exp_r.index, exp_r.owned,
                                     o_source_part, o_source_index, o_owned);
                    end
                end
            end
            if (hold_cycles != 0) begin
                i_out_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap    <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap    <= gap_length();
            end
        end
    end

    // Long receiver hold-off, counted in its own process.
    always @(posedge i_clk) begin
        if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("[concat_gather_address_top] ERROR");
            $finish;
        end
    end

    // Writes one register through the configuration port and mirrors it.
    task automatic write_reg(input t_reg_idx ridx, input logic [DataW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(ridx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (ridx)
            REG_PART_COUNT:  cfg_count = value[CountW-1:0];
            REG_LEN_PART0:   cfg_len[0] = value[LenW-1:0];
            REG_LEN_PART1:   cfg_len[1] = value[LenW-1:0];
            REG_LEN_PART2:   cfg_len[2] = value[LenW-1:0];
            REG_LEN_PART3:   cfg_len[3] = value[LenW-1:0];
            REG_INNER_SIZE:  cfg_inner = value[LenW-1:0];
            REG_AXIS_LENGTH: cfg_axis = value[LenW-1:0];
            default: ;
        endcase
    endtask

    // Waits until every queued item has been sent and answered.
    task automatic drain();
        while (index_queue.size() != 0 || i_in_valid || gather_queue.size() != 0)
            @(posedge i_clk);
        repeat (PipeDepth + 5) @(posedge i_clk);
    endtask

    task automatic set_shape(input logic [2:0] cnt, input logic [15:0] l0, l1, l2, l3,
                             input logic [15:0] inner, axis);
        write_reg(REG_PART_COUNT, 32'(cnt));
        write_reg(REG_LEN_PART0, 32'(l0));
        write_reg(REG_LEN_PART1, 32'(l1));
        write_reg(REG_LEN_PART2, 32'(l2));
        write_reg(REG_LEN_PART3, 32'(l3));
        write_reg(REG_INNER_SIZE, 32'(inner));
        write_reg(REG_AXIS_LENGTH, 32'(axis));
    endtask

    // Random indexes: mostly within a few output slabs, some over the full range.
    task automatic queue_random(input int unsigned count);
        logic [31:0] span;
        span = 32'(cfg_axis) * 32'(cfg_inner);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0 || span == 0)
                index_queue.push_back($urandom);
            else
                index_queue.push_back($urandom_range(0, (span > 32'h3FFFFFF) ? 32'hFFFFFFFF
                                                     : span * 8));
        end
    endtask

    initial begin
        cfg_count = 3'd2;
        cfg_len   = '{default: '0};
        cfg_inner = 16'd1;
        cfg_axis  = 16'd1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With reset values every part is empty, so nothing is owned.
        index_queue.push_back(32'd0);
        index_queue.push_back(32'hFFFFFFFF);
        drain();

        // A typical four-way concatenation with the special cases.
        set_shape(3'd4, 16'd3, 16'd0, 16'd5, 16'd2, 16'd7, 16'd10);
        for (int k = 0; k < 12; k++) index_queue.push_back(32'(k * 7));
        index_queue.push_back(32'hFFFFFFFF);
        index_queue.push_back(32'h80000000);
        index_queue.push_back(32'h55555555);
        index_queue.push_back(32'hAAAAAAAA);
        drain();

        // Axis longer than the parts cover: unowned tail; clamped part count.
        set_shape(3'd7, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd9);
        for (int k = 0; k < 18; k++) index_queue.push_back(32'(k));
        drain();

        // Zero divisors and zero or one part.
        write_reg(REG_INNER_SIZE, 32'h0);
        index_queue.push_back(32'd5);
        drain();
        write_reg(REG_INNER_SIZE, 32'hFFFF0003);
        write_reg(REG_AXIS_LENGTH, 32'h0);
        index_queue.push_back(32'd5);
        drain();
        write_reg(REG_AXIS_LENGTH, 32'd4);
        write_reg(REG_PART_COUNT, 32'd0);
        index_queue.push_back(32'd1);
        drain();
        write_reg(REG_PART_COUNT, 32'd1);
        for (int k = 0; k < 6; k++) index_queue.push_back(32'(k));
        drain();

        // Maximal sizes.
        set_shape(3'd4, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF);
        queue_random(60);
        drain();

        // Random shapes; long receiver hold-off while the sender keeps going.
        for (int ph = 0; ph < 8; ph++) begin
            set_shape(3'($urandom_range(2, 4)), 16'($urandom_range(0, 20)),
                      16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                      16'($urandom), 16'($urandom_range(1, 50)), 16'($urandom_range(1, 60)));
            if (ph == 2) hold_cycles = 300;
            queue_random(ph == 7 ? 56 : 55);
            drain();
        end

        if (mismatches == 0 && gather_queue.size() == 0)
            $display("[concat_gather_address_top] OK");
        else
            $display("[concat_gather_address_top] ERROR");
        $finish;
    end

endmodule
